// ===== rtl/wsd_pkg.sv =====
// ----------------------------------------------------------------------------
// wsd_pkg: shared types and constants for the wheel speed desaturation block
// Holds the limit register width, its reset value and the decision flags.
// ----------------------------------------------------------------------------
package wsd_pkg;

   localparam int LIMIT_WIDTH = 15;
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = LIMIT_WIDTH'(127);

   // quotient mag*L/M never exceeds L, so it has as many bits as the limit
   localparam int QUOT_WIDTH = LIMIT_WIDTH;

   typedef struct packed {
      logic zero;    // limit or peak zero: force outputs to zero
      logic pass;    // project mode within limit: speeds unchanged
   } flags_type;

endpackage

// ===== rtl/wsd_if.sv =====
// ----------------------------------------------------------------------------
// wsd_if: channel interfaces of the wheel speed desaturation block
// Request, response and limit register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface wsd_req_if #(parameter int SPEED_WIDTH = 16);
   logic                          valid;
   logic                          ready;
   logic                          action;
   logic signed [SPEED_WIDTH-1:0] left_front_speed;
   logic signed [SPEED_WIDTH-1:0] left_back_speed;
   logic signed [SPEED_WIDTH-1:0] right_front_speed;
   logic signed [SPEED_WIDTH-1:0] right_back_speed;

   modport source (output valid, action, left_front_speed, left_back_speed,
                   right_front_speed, right_back_speed, input ready);
   modport sink (input valid, action, left_front_speed, left_back_speed,
                 right_front_speed, right_back_speed, output ready);
endinterface

interface wsd_rsp_if #(parameter int SPEED_WIDTH = 16);
   logic                          valid;
   logic                          ready;
   logic signed [SPEED_WIDTH-1:0] left_front_out;
   logic signed [SPEED_WIDTH-1:0] left_back_out;
   logic signed [SPEED_WIDTH-1:0] right_front_out;
   logic signed [SPEED_WIDTH-1:0] right_back_out;
   logic                          was_scaled;
   logic                          zeroed;

   modport source (output valid, left_front_out, left_back_out, right_front_out,
                   right_back_out, was_scaled, zeroed, input ready);
   modport sink (input valid, left_front_out, left_back_out, right_front_out,
                 right_back_out, was_scaled, zeroed, output ready);
endinterface

interface wsd_csr_if;
   logic                              valid;
   logic                              ready;
   logic [wsd_pkg::LIMIT_WIDTH-1:0]   speed_limit;

   modport source (output valid, speed_limit, input ready);
   modport sink (input valid, speed_limit, output ready);
endinterface

// ===== rtl/wsd_lane.sv =====
// ----------------------------------------------------------------------------
// wsd_lane: one wheel's scaling lane
// Multiplies the magnitude by the limit, then divides by the peak in a
// pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module wsd_lane #(
   parameter int SPEED_WIDTH = 16
) (
   input  logic                             clock,
   input  logic                             en,
   input  logic [SPEED_WIDTH-1:0]           mag,
   input  logic                             neg,
   input  logic [SPEED_WIDTH-1:0]           raw,
   input  logic [wsd_pkg::LIMIT_WIDTH-1:0]  lim,
   input  logic [SPEED_WIDTH-1:0]           peak,
   output logic [wsd_pkg::QUOT_WIDTH-1:0]   quot,
   output logic                             neg_out,
   output logic [SPEED_WIDTH-1:0]           raw_out
);
   localparam int QW = wsd_pkg::QUOT_WIDTH;
   localparam int PW = SPEED_WIDTH + QW;

   logic [SPEED_WIDTH-1:0] rem_ff [0:QW];
   logic [QW-1:0]          lo_ff  [0:QW];
   logic [QW-1:0]          q_ff   [0:QW];
   logic [SPEED_WIDTH-1:0] div_ff [0:QW];
   logic                   neg_ff [0:QW];
   logic [SPEED_WIDTH-1:0] raw_ff [0:QW];
   logic [PW-1:0]          prod;

   assign prod = PW'(mag) * PW'(lim);

   always_ff @(posedge clock) begin
      if (en) begin
         // product < peak * 2^QW, so its upper part is already below the peak
         rem_ff[0] <= prod[PW-1:QW];
         lo_ff[0]  <= prod[QW-1:0];
         q_ff[0]   <= '0;
         div_ff[0] <= peak;
         neg_ff[0] <= neg;
         raw_ff[0] <= raw;
      end
   end

   for (genvar k = 0; k < QW; k++) begin : g_div
      logic [SPEED_WIDTH:0] trial;
      logic [SPEED_WIDTH:0] diff;
      logic                 ge;

      assign trial = {rem_ff[k], lo_ff[k][QW-1]};
      assign diff  = trial - {1'b0, div_ff[k]};
      assign ge    = trial >= {1'b0, div_ff[k]};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= ge ? diff[SPEED_WIDTH-1:0] : trial[SPEED_WIDTH-1:0];
            lo_ff[k+1]  <= {lo_ff[k][QW-2:0], 1'b0};
            q_ff[k+1]   <= {q_ff[k][QW-2:0], ge};
            div_ff[k+1] <= div_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            raw_ff[k+1] <= raw_ff[k];
         end
      end
   end

   assign quot    = q_ff[QW];
   assign neg_out = neg_ff[QW];
   assign raw_out = raw_ff[QW];

endmodule

// ===== rtl/wheel_speed_desaturation.sv =====
// ----------------------------------------------------------------------------
// wheel_speed_desaturation: four wheel speed limiter
// Finds the peak wheel magnitude and scales all four speeds by limit/peak.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one request: mode bit and four signed wheel speeds.
//   rsp_chan returns one result per request, in order: four speeds plus the
//   was_scaled and zeroed flags. csr_chan writes the speed limit; it is always
//   ready and should only be written while no request is in flight.
//   Throughput: one request per cycle unless the receiver stalls. Four lanes
//   each run a multiplier and a 15-stage pipelined divider (one quotient bit
//   per stage); a front stage takes magnitudes and the peak, a merge stage
//   picks zero, pass or scaled. The whole pipeline advances when the result
//   register is empty or being taken; while the receiver stalls a full result
//   register, req_ready drops. Reset empties the pipeline and sets the limit
//   to 127.
// ----------------------------------------------------------------------------
module wheel_speed_desaturation #(
   parameter int SPEED_WIDTH = 16
) (
   input  logic clock,
   input  logic reset,
   wsd_req_if.sink   req_chan,
   wsd_rsp_if.source rsp_chan,
   wsd_csr_if.sink   csr_chan
);
   localparam int W  = SPEED_WIDTH;
   localparam int QW = wsd_pkg::QUOT_WIDTH;
   localparam int LW = wsd_pkg::LIMIT_WIDTH;
   localparam int CW = (W > QW + 1) ? W : QW + 1;
   localparam logic [CW-1:0] MAXPOS = (CW'(1) << (W - 1)) - CW'(1);

   logic [LW-1:0] limit_ff;
   logic          en;

   // front stage
   logic                va_ff;
   logic                act_ff;
   logic [LW-1:0]       la_ff;
   logic [W-1:0]        raw_ff [0:3];
   logic [W-1:0]        in_raw [0:3];
   logic [W-1:0]        mag    [0:3];
   logic                neg    [0:3];
   logic [W-1:0]        peak;
   logic [W-1:0]        pk01;
   logic [W-1:0]        pk23;
   wsd_pkg::flags_type  fa;

   // lane-aligned control line
   logic                vl_ff [0:QW];
   wsd_pkg::flags_type  fl_ff [0:QW];

   logic [QW-1:0]       quot    [0:3];
   logic                neg_out [0:3];
   logic [W-1:0]        raw_out [0:3];
   logic [W-1:0]        res     [0:3];

   logic                rv_ff;
   logic [W-1:0]        out_ff [0:3];
   logic                scaled_ff;
   logic                zeroed_ff;

   assign en             = !rv_ff || rsp_chan.ready;
   assign req_chan.ready = en;
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= wsd_pkg::LIMIT_RESET;
      end else if (csr_chan.valid) begin
         limit_ff <= csr_chan.speed_limit;
      end
   end

   assign in_raw[0] = req_chan.left_front_speed;
   assign in_raw[1] = req_chan.left_back_speed;
   assign in_raw[2] = req_chan.right_front_speed;
   assign in_raw[3] = req_chan.right_back_speed;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (en) begin
         va_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         act_ff <= req_chan.action;
         la_ff  <= limit_ff;
         for (int i = 0; i < 4; i++) begin
            raw_ff[i] <= in_raw[i];
         end
      end
   end

   // most negative speed gives 2^(W-1), which still fits unsigned in W bits
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         neg[i] = raw_ff[i][W-1];
         mag[i] = neg[i] ? (~raw_ff[i] + W'(1)) : raw_ff[i];
      end
   end

   assign pk01 = (mag[0] > mag[1]) ? mag[0] : mag[1];
   assign pk23 = (mag[2] > mag[3]) ? mag[2] : mag[3];
   assign peak = (pk01 > pk23) ? pk01 : pk23;

   // compare wide enough for both the peak and the full limit
   assign fa.zero = (la_ff == '0) || (peak == '0);
   assign fa.pass = !act_ff && (CW'(peak) <= CW'(la_ff));

   for (genvar l = 0; l < 4; l++) begin : g_lane
      wsd_lane #(.SPEED_WIDTH(W)) u_lane (
         .clock   (clock),
         .en      (en),
         .mag     (mag[l]),
         .neg     (neg[l]),
         .raw     (raw_ff[l]),
         .lim     (la_ff),
         .peak    (peak),
         .quot    (quot[l]),
         .neg_out (neg_out[l]),
         .raw_out (raw_out[l])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= QW; k++) begin
            vl_ff[k] <= 1'b0;
         end
      end else if (en) begin
         vl_ff[0] <= va_ff;
         for (int k = 0; k < QW; k++) begin
            vl_ff[k+1] <= vl_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fl_ff[0] <= fa;
         for (int k = 0; k < QW; k++) begin
            fl_ff[k+1] <= fl_ff[k];
         end
      end
   end

   // merge: saturate the quotient, reapply the sign, select by decision
   always_comb begin
      logic [CW-1:0] qx;
      logic [W-1:0]  m;
      for (int i = 0; i < 4; i++) begin
         qx = CW'(quot[i]);
         m  = (qx > MAXPOS) ? MAXPOS[W-1:0] : qx[W-1:0];
         if (fl_ff[QW].zero) begin
            res[i] = '0;
         end else if (fl_ff[QW].pass) begin
            res[i] = raw_out[i];
         end else begin
            res[i] = neg_out[i] ? (~m + W'(1)) : m;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (en) begin
         rv_ff <= vl_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            out_ff[i] <= res[i];
         end
         zeroed_ff <= fl_ff[QW].zero;
         scaled_ff <= !fl_ff[QW].zero && !fl_ff[QW].pass;
      end
   end

   assign rsp_chan.valid           = rv_ff;
   assign rsp_chan.left_front_out  = out_ff[0];
   assign rsp_chan.left_back_out   = out_ff[1];
   assign rsp_chan.right_front_out = out_ff[2];
   assign rsp_chan.right_back_out  = out_ff[3];
   assign rsp_chan.was_scaled      = scaled_ff;
   assign rsp_chan.zeroed          = zeroed_ff;

   a_accept_enters : assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> va_ff)
      else $error("accepted request did not enter the front stage");

   a_flags_excl : assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> !(zeroed_ff && scaled_ff))
      else $error("result both zeroed and scaled");

   a_zero_outs : assert property (@(posedge clock) disable iff (reset)
      (rv_ff && zeroed_ff) |-> (out_ff[0] == '0 && out_ff[1] == '0 &&
                                out_ff[2] == '0 && out_ff[3] == '0))
      else $error("zeroed result carries nonzero speed");

endmodule

// ===== dv/wsd_tb_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_tb_if: testbench-side aid for the wheel speed desaturation channels
// The block's channel interfaces come from the RTL; this file holds the
// expected-result record the scoreboard stores.
// ----------------------------------------------------------------------------
package wsd_tb_pkg;
   typedef struct {
      logic signed [15:0] lf, lb, rf, rb;
      logic               scaled;
      logic               zeroed;
   } wheel_result_type;
endpackage

// ===== dv/wheel_speed_desaturation_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wheel_speed_desaturation_tb: self-checking bench for the speed limiter
// Drives directed and random requests under several limits, predicts each
// result with a local model of the peak/scale rule and checks it in order.
// ----------------------------------------------------------------------------
module wheel_speed_desaturation_tb;

   localparam int W = 16;

   class wheel_scoreboard;
      wsd_tb_pkg::wheel_result_type pending[$];
      logic [wsd_pkg::LIMIT_WIDTH-1:0] limit = wsd_pkg::LIMIT_RESET;
      int errors = 0;

      function automatic logic [W:0] mag_of(logic signed [W-1:0] v);
         return v[W-1] ? (W+1)'(-$signed({v[W-1], v})) : (W+1)'(v);
      endfunction

      function automatic logic signed [W-1:0] scale_one(logic signed [W-1:0] v,
                                                        logic [W:0] peak);
         logic [47:0] q;
         q = (48'(mag_of(v)) * 48'(limit)) / 48'(peak);
         if (q > 48'(2**(W-1) - 1)) q = 48'(2**(W-1) - 1);
         return v[W-1] ? -$signed(W'(q)) : $signed(W'(q));
      endfunction

      function void note_request(logic act, logic signed [W-1:0] s[4]);
         wsd_tb_pkg::wheel_result_type r;
         logic [W:0] peak;
         logic signed [W-1:0] o[4];
         peak = 0;
         foreach (s[i]) if (mag_of(s[i]) > peak) peak = mag_of(s[i]);
         r.scaled = 0; r.zeroed = 0;
         if (limit == 0 || peak == 0) begin
            foreach (o[i]) o[i] = 0;
            r.zeroed = 1;
         end else if (!act && peak <= (W+1)'(limit)) begin
            o = s;
         end else begin
            foreach (o[i]) o[i] = scale_one(s[i], peak);
            r.scaled = 1;
         end
         r.lf = o[0]; r.lb = o[1]; r.rf = o[2]; r.rb = o[3];
         pending.push_back(r);
      endfunction

      function void check_result(wsd_tb_pkg::wheel_result_type got);
         wsd_tb_pkg::wheel_result_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result lf=%0d", $time, got.lf);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.lf !== e.lf) begin
            $display("%0t: lf exp %0d got %0d", $time, e.lf, got.lf); errors++;
         end
         if (got.lb !== e.lb) begin
            $display("%0t: lb exp %0d got %0d", $time, e.lb, got.lb); errors++;
         end
         if (got.rf !== e.rf) begin
            $display("%0t: rf exp %0d got %0d", $time, e.rf, got.rf); errors++;
         end
         if (got.rb !== e.rb) begin
            $display("%0t: rb exp %0d got %0d", $time, e.rb, got.rb); errors++;
         end
         if (got.scaled !== e.scaled) begin
            $display("%0t: was_scaled exp %0b got %0b", $time, e.scaled, got.scaled);
            errors++;
         end
         if (got.zeroed !== e.zeroed) begin
            $display("%0t: zeroed exp %0b got %0b", $time, e.zeroed, got.zeroed);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   wsd_req_if #(W) req_chan();
   wsd_rsp_if #(W) rsp_chan();
   wsd_csr_if csr_chan();

   wheel_speed_desaturation #(.SPEED_WIDTH(W)) u_top (
      .clock(clock), .reset(reset),
      .req_chan(req_chan), .rsp_chan(rsp_chan), .csr_chan(csr_chan)
   );

   wheel_scoreboard sb = new();
   int hold_cycles = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      req_chan.valid = 0; req_chan.action = 0;
      req_chan.left_front_speed = 0; req_chan.left_back_speed = 0;
      req_chan.right_front_speed = 0; req_chan.right_back_speed = 0;
      rsp_chan.ready = 0;
      csr_chan.valid = 0; csr_chan.speed_limit = 0;
   end

   // accepted requests are noted at the edge they happen
   always @(posedge clock) begin
      logic signed [W-1:0] s[4];
      if (!reset && req_chan.valid && req_chan.ready) begin
         s[0] = req_chan.left_front_speed; s[1] = req_chan.left_back_speed;
         s[2] = req_chan.right_front_speed; s[3] = req_chan.right_back_speed;
         sb.note_request(req_chan.action, s);
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         wsd_tb_pkg::wheel_result_type g;
         g.lf = rsp_chan.left_front_out; g.lb = rsp_chan.left_back_out;
         g.rf = rsp_chan.right_front_out; g.rb = rsp_chan.right_back_out;
         g.scaled = rsp_chan.was_scaled; g.zeroed = rsp_chan.zeroed;
         sb.check_result(g);
      end
   end

   // receiver: random stalls, plus a long hold-off when hold_cycles is set
   initial begin
      int w;
      @(negedge reset);
      forever begin
         if (hold_cycles > 0) begin
            rsp_chan.ready <= 0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end
         w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
         if (w > 0) begin
            rsp_chan.ready <= 0;
            repeat (w) @(posedge clock);
         end
         rsp_chan.ready <= 1;
         @(posedge clock);
      end
   end

   task automatic send_speeds(logic act, logic signed [W-1:0] a, b, c, d,
                              bit gaps = 1);
      int w;
      w = gaps ? $urandom_range(0, 9) : 0;
      if (w > 0) begin
         req_chan.valid <= 0;
         repeat (w) @(posedge clock);
      end
      req_chan.valid <= 1; req_chan.action <= act;
      req_chan.left_front_speed <= a; req_chan.left_back_speed <= b;
      req_chan.right_front_speed <= c; req_chan.right_back_speed <= d;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic drain_then_set_limit(logic [wsd_pkg::LIMIT_WIDTH-1:0] lim);
      req_chan.valid <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (25) @(posedge clock);
      csr_chan.valid <= 1; csr_chan.speed_limit <= lim;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 0;
      sb.limit = lim;
   endtask

   function automatic logic signed [W-1:0] rand_speed(int peak);
      case ($urandom_range(0, 5))
         0: return -16'sd32768;
         1: return 16'sd32767;
         2: return $signed(W'($urandom()));
         default: return $signed(W'($urandom_range(0, 2 * peak) - peak));
      endcase
   endfunction

   task automatic random_burst(int n, int peak, bit gaps);
      repeat (n) send_speeds(1'($urandom_range(0, 1)), rand_speed(peak), rand_speed(peak),
                             rand_speed(peak), rand_speed(peak), gaps);
   endtask

   initial begin
      logic [wsd_pkg::LIMIT_WIDTH-1:0] limits[6] = '{15'd0, 15'd1, 15'd32767, 15'd1000,
                                                    15'd300, 15'd127};
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed, reset limit 127
      send_speeds(0, 0, 0, 0, 0);
      send_speeds(1, 0, 0, 0, 0);
      send_speeds(0, 100, -50, 127, -127);
      send_speeds(1, 100, -50, 127, -127);
      send_speeds(0, 128, 1, -1, 0);
      send_speeds(1, 10, -3, 7, 1);
      send_speeds(0, -16'sd32768, 5, 0, 0);
      send_speeds(1, -16'sd32768, 16'sd32767, -16'sd32767, 1);
      send_speeds(0, 16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768);
      send_speeds(0, 16'sh5555, -16'sh2aab, 16'sh00ff, -16'sh7f00);
      drain_then_set_limit(15'd32767);
      send_speeds(0, -16'sd32768, 3, -3, 0);
      send_speeds(1, -16'sd32768, 3, -3, 0);
      send_speeds(0, 16'sd32767, -16'sd32767, 1, 2);
      send_speeds(1, 1, -1, 0, 0);
      drain_then_set_limit(15'd0);
      send_speeds(0, 5, 6, 7, 8);
      send_speeds(1, -16'sd32768, 6, 7, 8);
      foreach (limits[k]) begin
         drain_then_set_limit(limits[k]);
         random_burst(60, limits[k] + 2, 1);
         random_burst(20, limits[k] + 2, 0);
      end
      // long receiver hold-off while requests keep coming
      hold_cycles = 80;
      random_burst(40, 200, 0);
      drain_then_set_limit(15'($urandom_range(1, 32767)));
      random_burst(25, 5000, 1);
      req_chan.valid <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (sb.errors == 0)
         $display("wheel_speed_desaturation test passed");
      else
         $display("wheel_speed_desaturation test failed");
      $finish;
   end

   initial begin
      #5ms;
      $display("wheel_speed_desaturation test failed");
      $finish;
   end
endmodule

// ===== files.f =====
rtl/wsd_pkg.sv
rtl/wsd_if.sv
rtl/wsd_lane.sv
rtl/wheel_speed_desaturation.sv
dv/wsd_tb_if.sv
dv/wheel_speed_desaturation_tb.sv
